@@ sv/ascii_frame_checksum_parser_defines.svh @@
// Assertion macros shared by the parser RTL.
`ifndef ASCII_FRAME_CHECKSUM_PARSER_DEFINES_SVH
`define ASCII_FRAME_CHECKSUM_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

`define AFCP_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define AFCP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define AFCP_ASSERT_IMPL(name, ante, cons, msg)

`define AFCP_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

@@ sv/afcp_pkg.sv @@
`default_nettype none

package afcp_pkg;

    localparam int BYTE_W   = 8;
    localparam int LIGHT_W  = 16;
    localparam int BTN_W    = 8;
    localparam int BTN_NUM  = 4;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END   = 2'd2;

    localparam logic [BYTE_W-1:0] START_RESET = 8'h40;
    localparam logic [BYTE_W-1:0] CHECK_RESET = 8'h58;
    localparam logic [BYTE_W-1:0] END_RESET   = 8'h0D;

    localparam logic [BYTE_W-1:0] CHAR_0 = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_9 = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_A = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_F = 8'h46;
    localparam logic [BYTE_W-1:0] CHAR_R = 8'h52;
    localparam logic [BYTE_W-1:0] CHAR_B = 8'h42;
    localparam logic [BYTE_W-1:0] CHAR_C = 8'h43;
    localparam logic [BYTE_W-1:0] CHAR_D = 8'h44;

    typedef enum logic [2:0] {
        MI_HUNT,
        MI_R,
        MI_A,
        MI_B,
        MI_C,
        MI_D,
        MI_END
    } marker_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_BAD_CHECK,
        ST_NO_MARKER
    } status_t;

    typedef struct packed {
        logic [LIGHT_W-1:0]            light_level;
        logic [BTN_NUM-1:0][BTN_W-1:0] buttons;
        status_t                       status;
    } result_t;

    // Byte that moves the parser from the given position to the next one.
    function automatic logic [BYTE_W-1:0] marker_code(input marker_t mi);
        logic [BYTE_W-1:0] code;
        unique case (mi)
            MI_R:    code = CHAR_R;
            MI_A:    code = CHAR_A;
            MI_B:    code = CHAR_B;
            MI_C:    code = CHAR_C;
            MI_D:    code = CHAR_D;
            default: code = '0;
        endcase
        return code;
    endfunction

    function automatic logic is_digit(input logic [BYTE_W-1:0] b);
        return (b >= CHAR_0) && (b <= CHAR_9);
    endfunction

    // Upper bit flags a byte that is not an uppercase hex digit.
    function automatic logic [4:0] hex_value(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] d;
        logic [4:0]        v;
        d = '0;
        if (is_digit(b)) begin
            d = b - CHAR_0;
            v = {1'b0, d[3:0]};
        end else if ((b >= CHAR_A) && (b <= CHAR_F)) begin
            d = b - CHAR_A + 8'd10;
            v = {1'b0, d[3:0]};
        end else begin
            v = 5'b1_0000;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

@@ sv/afcp_byte_if.sv @@
`default_nettype none

interface afcp_byte_if;
    logic                           valid;
    logic                           ready;
    logic [afcp_pkg::BYTE_W-1:0]    rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ sv/afcp_result_if.sv @@
`default_nettype none

interface afcp_result_if;
    logic                           valid;
    logic                           ready;
    logic [afcp_pkg::LIGHT_W-1:0]   light_level;
    logic [afcp_pkg::BTN_W-1:0]     button_a;
    logic [afcp_pkg::BTN_W-1:0]     button_b;
    logic [afcp_pkg::BTN_W-1:0]     button_c;
    logic [afcp_pkg::BTN_W-1:0]     button_d;
    logic [afcp_pkg::STATUS_W-1:0]  status;

    modport source (
        output valid, output light_level, output button_a, output button_b,
        output button_c, output button_d, output status, input ready
    );
    modport sink (
        input valid, input light_level, input button_a, input button_b,
        input button_c, input button_d, input status, output ready
    );
endinterface

`default_nettype wire

@@ sv/afcp_core.sv @@
`default_nettype none
`include "ascii_frame_checksum_parser_defines.svh"

module afcp_core #(
    parameter int MAX_FRAME_LEN = 64
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [afcp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [afcp_pkg::BYTE_W-1:0]        cfg_data,
    input  wire logic                               take,
    input  wire logic [afcp_pkg::BYTE_W-1:0]        rx_byte,
    output logic                                    res_push,
    output afcp_pkg::result_t                       res
);

    localparam logic [afcp_pkg::LEN_W:0] MAX_LEN = (afcp_pkg::LEN_W + 1)'(MAX_FRAME_LEN);

    logic [afcp_pkg::BYTE_W-1:0] start_reg, check_reg, end_reg;

    afcp_pkg::marker_t                                      mi_reg, mi_next;
    logic [afcp_pkg::LEN_W-1:0]                             len_reg, len_next;
    logic [afcp_pkg::BYTE_W-1:0]                            sum_reg, sum_next;
    logic                                                   frozen_reg, frozen_next;
    logic [1:0]                                             hexpos_reg, hexpos_next;
    logic [afcp_pkg::BYTE_W-1:0]                            rcv_reg, rcv_next;
    logic                                                   mis_reg, mis_next;
    logic                                                   de_reg, de_next;
    logic [afcp_pkg::LIGHT_W-1:0]                           light_reg, light_next;
    logic [afcp_pkg::BTN_NUM-1:0][afcp_pkg::BTN_W-1:0]      btn_reg, btn_next;

    // Check-path update of a byte inside a frame.
    logic [afcp_pkg::BYTE_W-1:0]    ck_sum;
    logic                           ck_frozen;
    logic [1:0]                     ck_hexpos;
    logic [afcp_pkg::BYTE_W-1:0]    ck_rcv;
    logic                           ck_mis;
    logic [4:0]                     hex_v;

    // Field-text update of a byte inside a frame.
    logic                                                   ft_ended;
    logic                                                   ft_de;
    logic [afcp_pkg::LIGHT_W-1:0]                           ft_light;
    logic [afcp_pkg::BTN_NUM-1:0][afcp_pkg::BTN_W-1:0]      ft_btn;
    logic [afcp_pkg::BYTE_W-1:0]                            digit;
    logic [1:0]                                             btn_sel;
    logic [2:0]                                             btn_off;

    logic [afcp_pkg::LEN_W:0] len_inc;
    logic                     end_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= afcp_pkg::START_RESET;
            check_reg <= afcp_pkg::CHECK_RESET;
            end_reg   <= afcp_pkg::END_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                afcp_pkg::CFG_START: start_reg <= cfg_data;
                afcp_pkg::CFG_CHECK: check_reg <= cfg_data;
                afcp_pkg::CFG_END:   end_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        hex_v     = afcp_pkg::hex_value(rx_byte);
        ck_sum    = sum_reg;
        ck_frozen = frozen_reg;
        ck_hexpos = hexpos_reg;
        ck_rcv    = rcv_reg;
        ck_mis    = mis_reg;
        if (!frozen_reg)
        begin
            if (rx_byte == check_reg)
                ck_frozen = 1'b1;
            else
                ck_sum = sum_reg + rx_byte;
        end
        else if (!hexpos_reg[1])
        begin
            ck_mis    = mis_reg | hex_v[4];
            ck_rcv    = {rcv_reg[3:0], hex_v[3:0]};
            ck_hexpos = hexpos_reg + 2'd1;
        end
    end

    always_comb
    begin
        digit    = rx_byte - afcp_pkg::CHAR_0;
        btn_off  = 3'(mi_reg) - 3'(afcp_pkg::MI_B);
        btn_sel  = btn_off[1:0];
        ft_ended = de_reg || ((mi_reg == afcp_pkg::MI_END) && (rx_byte == check_reg))
                   || !afcp_pkg::is_digit(rx_byte);
        ft_de    = de_reg;
        ft_light = light_reg;
        ft_btn   = btn_reg;
        if (mi_reg >= afcp_pkg::MI_A)
        begin
            ft_de = ft_ended;
            if (!ft_ended)
            begin
                if (mi_reg == afcp_pkg::MI_A)
                    ft_light = (light_reg << 3) + (light_reg << 1)
                               + {{(afcp_pkg::LIGHT_W - 4){1'b0}}, digit[3:0]};
                else
                    ft_btn[btn_sel] = (btn_reg[btn_sel] << 3) + (btn_reg[btn_sel] << 1)
                                      + {{(afcp_pkg::BTN_W - 4){1'b0}}, digit[3:0]};
            end
        end
    end

    assign len_inc = {1'b0, len_reg} + {{afcp_pkg::LEN_W{1'b0}}, 1'b1};
    assign end_hit = take && (mi_reg == afcp_pkg::MI_END) && (len_inc <= MAX_LEN)
                     && (rx_byte == end_reg);

    // Next state of the frame tracker.
    always_comb
    begin
        mi_next     = mi_reg;
        len_next    = len_reg;
        sum_next    = sum_reg;
        frozen_next = frozen_reg;
        hexpos_next = hexpos_reg;
        rcv_next    = rcv_reg;
        mis_next    = mis_reg;
        de_next     = de_reg;
        light_next  = light_reg;
        btn_next    = btn_reg;
        if (take)
        begin
            if (mi_reg == afcp_pkg::MI_HUNT)
            begin
                if (rx_byte == start_reg)
                begin
                    mi_next     = afcp_pkg::MI_R;
                    len_next    = afcp_pkg::LEN_W'(1);
                    hexpos_next = '0;
                    rcv_next    = '0;
                    mis_next    = 1'b0;
                    de_next     = 1'b0;
                    light_next  = '0;
                    btn_next    = '0;
                    frozen_next = (rx_byte == check_reg);
                    sum_next    = (rx_byte == check_reg) ? '0 : rx_byte;
                end
            end
            else if ((len_inc > MAX_LEN) || end_hit)
            begin
                // Overlong frames are dropped; a closed frame starts over too.
                mi_next     = afcp_pkg::MI_HUNT;
                len_next    = '0;
                sum_next    = '0;
                frozen_next = 1'b0;
                hexpos_next = '0;
                rcv_next    = '0;
                mis_next    = 1'b0;
                de_next     = 1'b0;
                light_next  = '0;
                btn_next    = '0;
            end
            else
            begin
                len_next    = len_inc[afcp_pkg::LEN_W-1:0];
                sum_next    = ck_sum;
                frozen_next = ck_frozen;
                hexpos_next = ck_hexpos;
                rcv_next    = ck_rcv;
                mis_next    = ck_mis;
                if ((mi_reg != afcp_pkg::MI_END)
                    && (rx_byte == afcp_pkg::marker_code(mi_reg)))
                begin
                    mi_next = afcp_pkg::marker_t'(3'(mi_reg) + 3'd1);
                    de_next = 1'b0;
                end
                else
                begin
                    de_next    = ft_de;
                    light_next = ft_light;
                    btn_next   = ft_btn;
                end
            end
        end
    end

    // Result of a closing byte, built from the updated check state.
    always_comb
    begin
        res_push = end_hit;
        res      = '0;
        if (!ck_frozen)
            res.status = afcp_pkg::ST_NO_MARKER;
        else if (ck_mis || !ck_hexpos[1] || (ck_rcv != ck_sum))
            res.status = afcp_pkg::ST_BAD_CHECK;
        else
        begin
            res.status      = afcp_pkg::ST_OK;
            res.light_level = light_reg;
            res.buttons     = btn_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mi_reg     <= afcp_pkg::MI_HUNT;
            len_reg    <= '0;
            sum_reg    <= '0;
            frozen_reg <= 1'b0;
            hexpos_reg <= '0;
            rcv_reg    <= '0;
            mis_reg    <= 1'b0;
            de_reg     <= 1'b0;
            light_reg  <= '0;
            btn_reg    <= '0;
        end
        else
        begin
            mi_reg     <= mi_next;
            len_reg    <= len_next;
            sum_reg    <= sum_next;
            frozen_reg <= frozen_next;
            hexpos_reg <= hexpos_next;
            rcv_reg    <= rcv_next;
            mis_reg    <= mis_next;
            de_reg     <= de_next;
            light_reg  <= light_next;
            btn_reg    <= btn_next;
        end
    end

    `AFCP_ASSERT_IMPL(a_len_tracks_hunt, 1'b1, ((mi_reg == afcp_pkg::MI_HUNT) == (len_reg == '0)), "frame length disagrees with hunting state")
    `AFCP_ASSERT_NEXT(a_hunt_after_result, res_push, ((mi_reg == afcp_pkg::MI_HUNT) && (len_reg == '0)), "parser did not return to hunting after a result")
    `AFCP_ASSERT_IMPL(a_hex_after_marker, (hexpos_reg != 2'd0), frozen_reg, "hex digits counted before the check marker")

endmodule

`default_nettype wire

@@ sv/afcp_out_q.sv @@
`default_nettype none
`include "ascii_frame_checksum_parser_defines.svh"

module afcp_out_q (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire afcp_pkg::result_t  din,
    output logic                    full,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output afcp_pkg::result_t       dout
);

    afcp_pkg::result_t  slot0_reg, slot0_next;
    afcp_pkg::result_t  slot1_reg, slot1_next;
    logic [1:0]         count_reg, count_next;
    logic               pop;

    assign full      = count_reg[1];
    assign out_valid = (count_reg != 2'd0);
    assign dout      = slot0_reg;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        if (pop)
        begin
            slot0_next = slot1_reg;
            count_next = count_reg - 2'd1;
        end
        if (push)
        begin
            // The newest item lands behind whatever is left after a pop.
            if (count_next == 2'd0)
                slot0_next = din;
            else
                slot1_next = din;
            count_next = count_next + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    `AFCP_ASSERT_IMPL(a_no_push_when_full, push, !full, "result pushed into a full queue")
    `AFCP_ASSERT_NEXT(a_count_hold, (!push && !pop), $stable(count_reg), "queue count moved without traffic")
    `AFCP_ASSERT_IMPL(a_count_bound, 1'b1, (count_reg != 2'd3), "queue count out of range")

endmodule

`default_nettype wire

@@ sv/ascii_frame_checksum_parser.sv @@
`default_nettype none

// Frame parser for @R<light>A<a>B<b>C<c>D<d>X<hh><CR> style byte streams. It takes one
// received byte per clock cycle while the result queue has room, as each byte only updates
// the frame tracker registers through shallow logic. The result of a frame is registered in
// a two-entry result queue and offered on the result channel; the queue lets the input keep
// flowing while a result waits, and the input stalls only when both entries are occupied.
// The user must write configuration registers through the plain write port only while idle;
// the block does not enforce this, and there is no clearing pass after reset.
module ascii_frame_checksum_parser #(
    parameter int MAX_FRAME_LEN = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [afcp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [afcp_pkg::BYTE_W-1:0]    cfg_data,
    afcp_byte_if.sink                           rx_ch,
    afcp_result_if.source                       res_ch
);

    logic               take;
    logic               res_push;
    logic               q_full;
    afcp_pkg::result_t  res;
    afcp_pkg::result_t  q_out;

    assign rx_ch.ready = !q_full;
    assign take        = rx_ch.valid && !q_full;

    afcp_core #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .rx_byte   (rx_ch.rx_byte),
        .res_push  (res_push),
        .res       (res)
    );

    afcp_out_q u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .din       (res),
        .full      (q_full),
        .out_valid (res_ch.valid),
        .out_ready (res_ch.ready),
        .dout      (q_out)
    );

    assign res_ch.light_level = q_out.light_level;
    assign res_ch.button_a    = q_out.buttons[0];
    assign res_ch.button_b    = q_out.buttons[1];
    assign res_ch.button_c    = q_out.buttons[2];
    assign res_ch.button_d    = q_out.buttons[3];
    assign res_ch.status      = q_out.status;

endmodule

`default_nettype wire
